// ===== hdl/ksa_pkg.sv =====
// ---------------------------------------------------------------------------
// ksa_pkg: keyed slot allocator shared definitions
// Widths, command, status and state codes, beat structs and cell interface types.
// ---------------------------------------------------------------------------
package ksa_pkg;

  localparam int MAX_SLOTS = 32;
  localparam int SLOT_W    = 6;
  localparam int KEY_W     = 32;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESERVE_ANY   = 3'd0,
    CMD_RESERVE_NAMED = 3'd1,
    CMD_RELEASE       = 3'd2,
    CMD_LOOKUP        = 3'd3,
    CMD_LIST_FREE     = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 3'd0,
    ST_NO_FREE     = 3'd1,
    ST_SLOT_BAD    = 3'd2,
    ST_KEY_UNKNOWN = 3'd3,
    ST_KEY_HELD    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DECIDE,
    S_RESULT,
    S_LIST
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [KEY_W-1:0]  client_key;
    logic [SLOT_W-1:0] slot_number;
  } in_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_out;
    logic              all_taken;
    logic              last;
  } out_beat_t;

  // broadcast to every cell
  typedef struct packed {
    logic claim_any;
    logic claim_named;
    logic release_key;
    logic list_clear;
    logic list_step;
  } cell_ctl_t;

  // passed from a cell to the next higher one
  typedef struct packed {
    logic hit;
    logic avail;
    logic unl;
  } cell_chain_t;

  typedef struct packed {
    logic avail;
    logic unl;
    logic named;
    logic first_hit;
    logic first_avail;
    logic first_unl;
  } cell_flag_t;

endpackage

// ===== hdl/ksa_cell.sv =====
// ---------------------------------------------------------------------------
// ksa_cell: one slot of the allocator
// Holds the free bit, owner key and list mark of one slot; resolves the
// lowest-match chains with its neighbors.
// ---------------------------------------------------------------------------
module ksa_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ksa_pkg::KEY_W-1:0]  key,
  input  logic [ksa_pkg::SLOT_W-1:0] req,
  input  logic [ksa_pkg::SLOT_W-1:0] idx,
  input  logic [ksa_pkg::SLOT_W-1:0] n,
  input  ksa_pkg::cell_ctl_t         ctl,
  input  ksa_pkg::cell_chain_t       chain_in,
  output ksa_pkg::cell_chain_t       chain_out,
  output ksa_pkg::cell_flag_t        flags
);
  import ksa_pkg::*;

  logic             free;
  logic             listed;
  logic             hit;
  logic [KEY_W-1:0] owner;
  logic             active;
  logic             avail;
  logic             unl;
  logic             named;
  logic             claim;

  assign active = (idx < n);
  assign avail  = free & active;
  assign unl    = avail & ~listed;
  assign named  = avail && (({1'b0, idx} + (SLOT_W+1)'(1)) == {1'b0, req});

  assign flags.avail       = avail;
  assign flags.unl         = unl;
  assign flags.named       = named;
  assign flags.first_hit   = hit & ~chain_in.hit;
  assign flags.first_avail = avail & ~chain_in.avail;
  assign flags.first_unl   = unl & ~chain_in.unl;

  assign chain_out.hit   = chain_in.hit | hit;
  assign chain_out.avail = chain_in.avail | avail;
  assign chain_out.unl   = chain_in.unl | unl;

  assign claim = (ctl.claim_any & flags.first_avail) | (ctl.claim_named & named);

  always_ff @(posedge clk) begin
    if (rst) begin
      free   <= 1'b1;
      listed <= 1'b0;
      hit    <= 1'b0;
    end else begin
      hit <= ~free & active & (owner == key);
      if (claim) begin
        free <= 1'b0;
      end else if (ctl.release_key && flags.first_hit) begin
        free <= 1'b1;
      end
      if (ctl.list_clear) begin
        listed <= 1'b0;
      end else if (ctl.list_step && flags.first_unl) begin
        listed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      owner <= key;
    end
  end

endmodule

// ===== hdl/keyed_slot_allocator.sv =====
// ---------------------------------------------------------------------------
// keyed_slot_allocator: lowest free slot allocator with key lookup
// Row of slot cells under a small sequencer, with a registered output beat.
// ---------------------------------------------------------------------------
// Input beats (in_valid/in_stall/in_data) carry a command, a client key and
// a slot number. Output beats (out_valid/out_stall/out_data) carry status,
// slot, all_taken and last. cfg_we/cfg_data write slot_count; the user
// writes it only while idle; the block has no guard for it. One command
// is worked at a time. A beat is taken in IDLE, the cells compare the key
// in EVAL, DECIDE picks the lowest matching or free slot and updates the
// cells, and RESULT loads the result into the output register once it can
// take it. List free emits one beat per free slot, one per cycle unless
// out_stall holds the output, or one no-free beat if none is free. The
// lowest-slot pick ripples combinationally through the cell row. in_stall
// is high whenever a command is in progress. The output register frees
// the input side: the next command is taken while a result waits. When
// out_stall is high the output beat holds and the sequencer waits. Reset
// frees every slot, sets slot_count to 32 and empties the output.
// ---------------------------------------------------------------------------
module keyed_slot_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ksa_pkg::in_beat_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ksa_pkg::out_beat_t         out_data,
  input  logic                       cfg_we,
  input  logic [ksa_pkg::SLOT_W-1:0] cfg_data
);
  import ksa_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [SLOT_W-1:0] slot_count;
  logic [SLOT_W-1:0] n_eff;
  in_beat_t          cur;
  status_t           res_status;
  status_t           res_status_next;
  logic [SLOT_W-1:0] res_slot;
  logic [SLOT_W-1:0] res_slot_next;
  cell_ctl_t         ctl;
  cell_chain_t       chain [MAX_SLOTS+1];
  cell_flag_t        flags [MAX_SLOTS];
  logic              hit_any;
  logic              avail_any;
  logic              named_ok;
  logic              more;
  logic [SLOT_W-1:0] hit_slot;
  logic [SLOT_W-1:0] avail_slot;
  logic [SLOT_W-1:0] unl_slot;
  logic              can_load;
  logic              out_load;
  out_beat_t         out_next;

  assign n_eff = (slot_count > SLOT_W'(MAX_SLOTS)) ? SLOT_W'(MAX_SLOTS) : slot_count;
  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    ksa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .key       (cur.client_key),
      .req       (cur.slot_number),
      .idx       (SLOT_W'(g)),
      .n         (n_eff),
      .ctl       (ctl),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .flags     (flags[g])
    );
  end

  assign hit_any   = chain[MAX_SLOTS].hit;
  assign avail_any = chain[MAX_SLOTS].avail;

  always_comb begin
    hit_slot   = '0;
    avail_slot = '0;
    unl_slot   = '0;
    named_ok   = 1'b0;
    more       = 1'b0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (flags[i].first_hit)   hit_slot   = hit_slot   | SLOT_W'(i + 1);
      if (flags[i].first_avail) avail_slot = avail_slot | SLOT_W'(i + 1);
      if (flags[i].first_unl)   unl_slot   = unl_slot   | SLOT_W'(i + 1);
      named_ok = named_ok | flags[i].named;
      more     = more | (flags[i].unl & ~flags[i].first_unl);
    end
  end

  assign in_stall = (state != S_IDLE);
  assign can_load = ~out_valid | ~out_stall;

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    ctl             = '0;
    out_load        = 1'b0;
    out_next        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = S_RESULT;
        case (cur.command)
          CMD_RESERVE_ANY, CMD_RESERVE_NAMED: begin
            if (hit_any) begin
              res_status_next = ST_KEY_HELD;
              res_slot_next   = hit_slot;
            end else if (cur.command == CMD_RESERVE_ANY) begin
              if (avail_any) begin
                ctl.claim_any   = 1'b1;
                res_status_next = ST_OK;
                res_slot_next   = avail_slot;
              end else begin
                res_status_next = ST_NO_FREE;
                res_slot_next   = '0;
              end
            end else if (named_ok) begin
              ctl.claim_named = 1'b1;
              res_status_next = ST_OK;
              res_slot_next   = cur.slot_number;
            end else begin
              res_status_next = ST_SLOT_BAD;
              res_slot_next   = '0;
            end
          end
          CMD_RELEASE: begin
            if (hit_any) begin
              ctl.release_key = 1'b1;
              res_status_next = ST_OK;
              res_slot_next   = hit_slot;
            end else begin
              res_status_next = ST_KEY_UNKNOWN;
              res_slot_next   = '0;
            end
          end
          CMD_LOOKUP: begin
            res_status_next = hit_any ? ST_OK : ST_KEY_UNKNOWN;
            res_slot_next   = hit_slot;
          end
          CMD_LIST_FREE: begin
            if (avail_any) begin
              ctl.list_clear = 1'b1;
              state_next     = S_LIST;
            end else begin
              res_status_next = ST_NO_FREE;
              res_slot_next   = '0;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_RESULT: begin
        if (can_load) begin
          out_load           = 1'b1;
          out_next.status    = res_status;
          out_next.slot_out  = res_slot;
          out_next.all_taken = ~avail_any;
          out_next.last      = 1'b1;
          state_next         = S_IDLE;
        end
      end
      S_LIST: begin
        if (can_load) begin
          out_load           = 1'b1;
          ctl.list_step      = 1'b1;
          out_next.status    = ST_OK;
          out_next.slot_out  = unl_slot;
          out_next.all_taken = ~avail_any;
          out_next.last      = ~more;
          if (!more) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_count <= SLOT_W'(32);
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        slot_count <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cur <= in_data;
    end
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    if (out_load) begin
      out_data <= out_next;
    end
  end

endmodule

// ===== hdl/ksa_checker.sv =====
// ---------------------------------------------------------------------------
// ksa_checker: port-level checks for the keyed slot allocator
// Watches the top-level ports over time; bound to keyed_slot_allocator.
// ---------------------------------------------------------------------------
module ksa_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input ksa_pkg::out_beat_t         out_data
);
  import ksa_pkg::*;

  // held output beat does not move
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // one command at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a command is in progress");

  // every refusal is a single-beat result
  a_refusal_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.last)
    else $error("non-ok result without last");

  a_ok_has_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_OK |-> out_data.slot_out != '0)
    else $error("ok result with slot zero");

  a_no_free_taken: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_NO_FREE |-> out_data.all_taken &&
    out_data.slot_out == '0)
    else $error("no-free result inconsistent");

endmodule

bind keyed_slot_allocator ksa_checker u_ksa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== sim/keyed_slot_allocator_tb.sv =====
// ---------------------------------------------------------------------------
// keyed_slot_allocator_tb: self-checking bench for the keyed slot allocator
// A directed table, then random command phases across several slot_count
// settings. A bit-level slot/key tracker, or a typed table row, predicts
// each result beat, checked one by one under random idling on both sides.
// ---------------------------------------------------------------------------
module keyed_slot_allocator_tb;
  import ksa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNDEF_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNDEF_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF_HI  = 3'd7;

  localparam int RAND_ITEMS   = 140;
  localparam int SETTLE_CYC   = 12;
  localparam int HOLD_CYC     = 150;
  localparam int QUIET_LIMIT  = 2000;
  localparam int KEY_POOL     = 8;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  logic      cfg_we;
  logic [SLOT_W-1:0] cfg_data;

  keyed_slot_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // slot/key tracker
  logic [MAX_SLOTS-1:0] free_map;
  logic [KEY_W-1:0]     holder_key [MAX_SLOTS];
  logic [SLOT_W-1:0]    count_reg;
  out_beat_t            step_beats[$];
  out_beat_t            slot_results_q[$];

  typedef struct {
    bit                is_cfg;
    logic [CMD_W-1:0]  command;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot_no;
    bit                typed;
    status_t           st;
    logic [SLOT_W-1:0] slot_exp;
    logic              taken_exp;
  } dir_row_t;

  dir_row_t         dir_table[$];
  logic [KEY_W-1:0] key_pool [KEY_POOL];

  int  fail_count;
  int  beats_seen;
  int  cmds_issued;
  int  list_runs;
  int  cfg_writes;
  bit  in_burst;
  bit  hold_req;
  bit  hold_done;

  function automatic int unsigned live_slots();
    return (count_reg > MAX_SLOTS) ? MAX_SLOTS : count_reg;
  endfunction

  function automatic logic [MAX_SLOTS-1:0] live_free();
    logic [MAX_SLOTS:0] m;
    m = ({{MAX_SLOTS{1'b0}}, 1'b1} << live_slots()) - 1'b1;
    return free_map & m[MAX_SLOTS-1:0];
  endfunction

  // lowest live held slot carrying this key, zero if none
  function automatic logic [SLOT_W-1:0] slot_of_key(input logic [KEY_W-1:0] key);
    logic [SLOT_W-1:0] s;
    for (int i = 0; i < live_slots(); i++) begin
      if (!free_map[i] && holder_key[i] == key) begin
        s = SLOT_W'(i + 1);
        return s;
      end
    end
    return '0;
  endfunction

  task automatic note_beat(input status_t st, input logic [SLOT_W-1:0] slot,
                           input logic last);
    out_beat_t r;
    r.status    = st;
    r.slot_out  = slot;
    r.all_taken = (live_free() == '0);
    r.last      = last;
    step_beats.push_back(r);
  endtask

  task automatic compute_slot_results(input in_beat_t b);
    logic [SLOT_W-1:0]    held;
    logic [SLOT_W-1:0]    s;
    logic [MAX_SLOTS-1:0] avail;
    int unsigned          n;
    int unsigned          pick;
    step_beats.delete();
    n     = live_slots();
    avail = live_free();
    held  = slot_of_key(b.client_key);
    case (b.command)
      CMD_RESERVE_ANY, CMD_RESERVE_NAMED: begin
        if (held != '0) begin
          note_beat(ST_KEY_HELD, held, 1'b1);
        end else if (b.command == CMD_RESERVE_ANY && avail == '0) begin
          note_beat(ST_NO_FREE, '0, 1'b1);
        end else if (b.command == CMD_RESERVE_NAMED &&
                     (b.slot_number == '0 || b.slot_number > n ||
                      !avail[b.slot_number - 1'b1])) begin
          note_beat(ST_SLOT_BAD, '0, 1'b1);
        end else begin
          if (b.command == CMD_RESERVE_ANY) begin
            for (pick = 0; pick < n; pick++)
              if (avail[pick]) break;
          end else begin
            pick = b.slot_number - 1;
          end
          free_map[pick]   = 1'b0;
          holder_key[pick] = b.client_key;
          s = SLOT_W'(pick + 1);
          note_beat(ST_OK, s, 1'b1);
        end
      end
      CMD_RELEASE: begin
        if (held == '0) begin
          note_beat(ST_KEY_UNKNOWN, '0, 1'b1);
        end else begin
          free_map[held - 1'b1] = 1'b1;
          note_beat(ST_OK, held, 1'b1);
        end
      end
      CMD_LOOKUP: begin
        note_beat((held != '0) ? ST_OK : ST_KEY_UNKNOWN, held, 1'b1);
      end
      CMD_LIST_FREE: begin
        if (avail == '0) begin
          note_beat(ST_NO_FREE, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            if (avail[i]) begin
              s = SLOT_W'(i + 1);
              note_beat(ST_OK, s, 1'b0);
            end
          end
          step_beats[step_beats.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  task automatic issue(input in_beat_t b, input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    compute_slot_results(b);
    foreach (step_beats[i]) slot_results_q.push_back(step_beats[i]);
    cmds_issued++;
    if (b.command == CMD_LIST_FREE) list_runs++;
  endtask

  // all results in, then room for a command that yields none
  task automatic settle();
    in_valid <= 1'b0;
    while (slot_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_count(input logic [SLOT_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    count_reg = v;
    cfg_writes++;
  endtask

  task automatic t_row(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                       input logic [SLOT_W-1:0] slot, input status_t st,
                       input logic [SLOT_W-1:0] slot_exp, input logic taken);
    dir_row_t r;
    r = '{1'b0, cmd, key, slot, 1'b1, st, slot_exp, taken};
    dir_table.push_back(r);
  endtask

  task automatic p_row(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                       input logic [SLOT_W-1:0] slot);
    dir_row_t r;
    r = '{1'b0, cmd, key, slot, 1'b0, ST_OK, '0, 1'b0};
    dir_table.push_back(r);
  endtask

  task automatic c_row(input logic [SLOT_W-1:0] v);
    dir_row_t r;
    r = '{1'b1, CMD_RESERVE_ANY, '0, v, 1'b0, ST_OK, '0, 1'b0};
    dir_table.push_back(r);
  endtask

  task automatic load_directed();
    //    command            key            slot  status          slot  taken
    t_row(CMD_LOOKUP,        32'h0000_0000, 6'd0,  ST_KEY_UNKNOWN, 6'd0,  1'b0);
    t_row(CMD_RELEASE,       32'hFFFF_FFFF, 6'd0,  ST_KEY_UNKNOWN, 6'd0,  1'b0);
    t_row(CMD_RESERVE_NAMED, 32'h0000_0001, 6'd0,  ST_SLOT_BAD,    6'd0,  1'b0);
    t_row(CMD_RESERVE_NAMED, 32'h0000_0001, 6'd63, ST_SLOT_BAD,    6'd0,  1'b0);
    p_row(CMD_LIST_FREE,     32'h0000_0000, 6'd0);
    t_row(CMD_RESERVE_ANY,   32'h0000_0000, 6'd0,  ST_OK,          6'd1,  1'b0);
    t_row(CMD_RESERVE_ANY,   32'h0000_0000, 6'd0,  ST_KEY_HELD,    6'd1,  1'b0);
    t_row(CMD_RESERVE_NAMED, 32'h0000_0000, 6'd5,  ST_KEY_HELD,    6'd1,  1'b0);
    t_row(CMD_RESERVE_NAMED, 32'hFFFF_FFFF, 6'd32, ST_OK,          6'd32, 1'b0);
    t_row(CMD_RESERVE_NAMED, 32'hA5A5_A5A5, 6'd32, ST_SLOT_BAD,    6'd0,  1'b0);
    t_row(CMD_LOOKUP,        32'hFFFF_FFFF, 6'd0,  ST_OK,          6'd32, 1'b0);
    p_row(CMD_UNDEF_MID,     32'h0000_0000, 6'd1);
    p_row(CMD_UNDEF_HI,      32'hFFFF_FFFF, 6'd63);
    p_row(CMD_LIST_FREE,     32'h0000_0000, 6'd0);
    t_row(CMD_RELEASE,       32'h0000_0000, 6'd0,  ST_OK,          6'd1,  1'b0);
    c_row(6'd1);
    // key above the live range is not seen, so it gets a second slot
    t_row(CMD_RESERVE_ANY,   32'hFFFF_FFFF, 6'd0,  ST_OK,          6'd1,  1'b1);
    t_row(CMD_RESERVE_ANY,   32'h0000_0007, 6'd0,  ST_NO_FREE,     6'd0,  1'b1);
    t_row(CMD_LIST_FREE,     32'h0000_0000, 6'd0,  ST_NO_FREE,     6'd0,  1'b1);
    t_row(CMD_RESERVE_NAMED, 32'h0000_0007, 6'd1,  ST_SLOT_BAD,    6'd0,  1'b1);
    c_row(6'd0);
    t_row(CMD_RESERVE_ANY,   32'h0000_0007, 6'd0,  ST_NO_FREE,     6'd0,  1'b1);
    t_row(CMD_LOOKUP,        32'hFFFF_FFFF, 6'd0,  ST_KEY_UNKNOWN, 6'd0,  1'b1);
    c_row(6'd63);
    // same key now held twice, lowest slot wins
    t_row(CMD_LOOKUP,        32'hFFFF_FFFF, 6'd0,  ST_OK,          6'd1,  1'b0);
    t_row(CMD_RELEASE,       32'hFFFF_FFFF, 6'd0,  ST_OK,          6'd1,  1'b0);
    t_row(CMD_LOOKUP,        32'hFFFF_FFFF, 6'd0,  ST_OK,          6'd32, 1'b0);
    t_row(CMD_RESERVE_NAMED, 32'h5555_AAAA, 6'd33, ST_SLOT_BAD,    6'd0,  1'b0);
  endtask

  task automatic make_random_beat(output in_beat_t b);
    int unsigned r;
    int unsigned n;
    n = live_slots();
    r = $urandom_range(0, 99);
    if (r < 30)      b.command = CMD_RESERVE_ANY;
    else if (r < 45) b.command = CMD_RESERVE_NAMED;
    else if (r < 68) b.command = CMD_RELEASE;
    else if (r < 83) b.command = CMD_LOOKUP;
    else if (r < 92) b.command = CMD_LIST_FREE;
    else if (r < 95) b.command = CMD_UNDEF_LO;
    else if (r < 98) b.command = CMD_UNDEF_MID;
    else             b.command = CMD_UNDEF_HI;
    if ($urandom_range(0, 9) == 0) b.client_key = $urandom();
    else b.client_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    r = $urandom_range(0, 9);
    if (r < 6 && n > 0) b.slot_number = SLOT_W'($urandom_range(1, n));
    else if (r < 8)     b.slot_number = SLOT_W'($urandom_range(0, n + 1));
    else                b.slot_number = SLOT_W'($urandom_range(0, 63));
  endtask

  task automatic check_field(input string name, input logic [SLOT_W-1:0] want,
                             input logic [SLOT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_beat(input out_beat_t got);
    out_beat_t want;
    beats_seen++;
    if (slot_results_q.size() == 0) begin
      $display("%0t: result beat with nothing pending: expected none, got %p",
               $time, got);
      fail_count++;
    end else begin
      want = slot_results_q.pop_front();
      check_field("status",    SLOT_W'(want.status),    SLOT_W'(got.status));
      check_field("slot_out",  want.slot_out,           got.slot_out);
      check_field("all_taken", SLOT_W'(want.all_taken), SLOT_W'(got.all_taken));
      check_field("last",      SLOT_W'(want.last),      SLOT_W'(got.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_beat(out_data);
  end

  // receiver: random stall/open stretches, plus one long hold on request
  initial begin : out_side
    int unsigned stall_left;
    int unsigned open_left;
    stall_left = 0;
    open_left  = 0;
    hold_done  = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYC;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (open_left > 0) begin
        out_stall <= 1'b0;
        open_left--;
      end else begin
        out_stall  <= 1'b0;
        stall_left = pick_gap();
        open_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 12);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no beat moved for %0d cycles", $time, QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    in_beat_t          b;
    out_beat_t         typed_beat;
    logic [SLOT_W-1:0] phase_counts[10];
    int                done_items;
    int                per_phase;
    clk        = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    hold_req   = 1'b0;
    in_burst   = 1'b0;
    fail_count = 0;
    beats_seen = 0;
    cmds_issued = 0;
    list_runs  = 0;
    cfg_writes = 0;
    free_map   = '1;
    count_reg  = 6'd32;
    foreach (holder_key[i]) holder_key[i] = '0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom();
    phase_counts = '{6'd4, 6'd32, 6'd1, 6'd12, 6'd0, 6'd63, 6'd2, 6'd33, 6'd7, 6'd32};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_directed();
    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg) begin
        settle();
        write_count(dir_table[i].slot_no);
      end else begin
        b.command     = dir_table[i].command;
        b.client_key  = dir_table[i].key;
        b.slot_number = dir_table[i].slot_no;
        issue(b, pick_gap());
        if (dir_table[i].typed) begin
          typed_beat.status    = dir_table[i].st;
          typed_beat.slot_out  = dir_table[i].slot_exp;
          typed_beat.all_taken = dir_table[i].taken_exp;
          typed_beat.last      = 1'b1;
          slot_results_q[slot_results_q.size() - 1] = typed_beat;
        end
      end
    end

    per_phase = RAND_ITEMS / 10;
    for (int p = 0; p < 10; p++) begin
      settle();
      write_count(phase_counts[p]);
      in_burst = ($urandom_range(0, 3) == 0);
      if (p == 1) hold_req = 1'b1;   // output backs up while inputs keep coming
      done_items = 0;
      while (done_items < per_phase) begin
        make_random_beat(b);
        issue(b, in_burst ? 0 : pick_gap());
        if (b.command <= CMD_LIST_FREE) done_items++;
      end
    end

    settle();
    $display("Ran %0d commands (%0d free-slot lists) and checked %0d result beats",
             cmds_issued, list_runs, beats_seen);
    $display("slot_count written %0d times, from 0 through 63, with a long output hold",
             cfg_writes);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ksa_pkg.sv
hdl/ksa_cell.sv
hdl/keyed_slot_allocator.sv
hdl/ksa_checker.sv
sim/keyed_slot_allocator_tb.sv
